// ===== rtl/tisfb_pkg.sv =====
// Shared types and constants for the three-image seam feather blend.
package tisfb_pkg;

    // Largest image width that the seam geometry honors.
    localparam int unsigned MAX_WIDTH = 4096;

    // Field widths.
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned COL_W    = 14;
    localparam int unsigned WIDTH_W  = 13;
    localparam int unsigned HALF_W   = 11;
    localparam int unsigned CFG_W    = 13;
    // Window length 2*half_window and ramp positions inside it.
    localparam int unsigned WIN_W    = HALF_W + 1;
    // Signed width that holds every seam boundary and column.
    localparam int unsigned GEO_W    = 16;
    // Product of a channel value and a ramp weight.
    localparam int unsigned PROD_W   = CHAN_W + WIN_W;

    // Scaling unit: one multiply stage, restoring divide stages, one rounding stage.
    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES     = CHAN_W / BITS_PER_STAGE;
    localparam int unsigned SCALE_LAT      = DIV_STAGES + 2;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH = 1'b0,
        REG_HALF_WINDOW = 1'b1
    } cfg_reg_t;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [2:0]       trio_t;

    // Seam geometry of one column.
    typedef struct packed {
        logic              below_first;   // left of the first ramp
        logic              in_first;      // inside the first ramp
        logic              below_second;  // left of the second ramp
        logic              in_second;     // inside the second ramp
        logic [WIN_W-1:0]  k_first;       // position inside the first ramp
        logic [WIN_W-1:0]  rest_first;    // window minus k_first
        logic [WIN_W-1:0]  k_second;      // position inside the second ramp
        logic [WIN_W-1:0]  rest_second;   // window minus k_second
        logic [WIN_W-1:0]  window;        // 2 * half_window
    } geo_t;

    // Side data carried alongside the first scaling pass.
    typedef struct packed {
        logic              below_first;
        logic              in_first;
        logic              below_second;
        logic              in_second;
        logic [WIN_W-1:0]  rest_second;
        logic [WIN_W-1:0]  window;
        trio_t             left_pix;
        trio_t             mid_pix;
        trio_t             right_pix;
    } side1_t;

    // Side data carried alongside the second scaling pass.
    typedef struct packed {
        logic              below_second;
        logic              in_second;
        trio_t             left_term;
        trio_t             right_term;
    } side2_t;

endpackage

// ===== rtl/tisfb_decode.sv =====
// Seam geometry decode: region flags and ramp weights for one canvas column.
module tisfb_decode (
    input  logic [tisfb_pkg::COL_W-1:0]   column,
    input  logic [tisfb_pkg::WIDTH_W-1:0] image_width,
    input  logic [tisfb_pkg::HALF_W-1:0]  half_window,
    output tisfb_pkg::geo_t               geo
);

    logic [tisfb_pkg::WIDTH_W-1:0]       width_sat;
    logic [tisfb_pkg::WIN_W-1:0]         window;
    logic signed [tisfb_pkg::GEO_W-1:0]  col_s;
    logic signed [tisfb_pkg::GEO_W-1:0]  first_lo;
    logic signed [tisfb_pkg::GEO_W-1:0]  first_hi;
    logic signed [tisfb_pkg::GEO_W-1:0]  second_lo;
    logic signed [tisfb_pkg::GEO_W-1:0]  second_hi;
    logic signed [tisfb_pkg::GEO_W-1:0]  k_first_full;
    logic signed [tisfb_pkg::GEO_W-1:0]  k_second_full;

    // Clamp the width and form the four seam boundaries.
    always_comb
    begin
        if (image_width > tisfb_pkg::WIDTH_W'(tisfb_pkg::MAX_WIDTH))
        begin
            width_sat = tisfb_pkg::WIDTH_W'(tisfb_pkg::MAX_WIDTH);
        end
        else
        begin
            width_sat = image_width;
        end
        window    = {half_window, 1'b0};
        col_s     = $signed(tisfb_pkg::GEO_W'(column));
        first_lo  = $signed(tisfb_pkg::GEO_W'(width_sat));
        first_hi  = first_lo + $signed(tisfb_pkg::GEO_W'(window));
        second_hi = $signed({tisfb_pkg::GEO_W'(width_sat)} << 1);
        second_lo = second_hi - $signed(tisfb_pkg::GEO_W'(window));
    end

    // Region flags and positions inside each ramp.
    always_comb
    begin
        k_first_full      = col_s - first_lo;
        k_second_full     = col_s - second_lo;
        geo.below_first   = col_s < first_lo;
        geo.in_first      = !(col_s < first_lo) && (col_s < first_hi);
        geo.below_second  = col_s < second_lo;
        geo.in_second     = !(col_s < second_lo) && (col_s < second_hi);
        geo.k_first       = k_first_full[tisfb_pkg::WIN_W-1:0];
        geo.k_second      = k_second_full[tisfb_pkg::WIN_W-1:0];
        geo.rest_first    = window - k_first_full[tisfb_pkg::WIN_W-1:0];
        geo.rest_second   = window - k_second_full[tisfb_pkg::WIN_W-1:0];
        geo.window        = window;
    end

endmodule

// ===== rtl/tisfb_scale.sv =====
// Pipelined round(value * weight / divisor), ties to even.
module tisfb_scale (
    input  logic                          clk,
    input  logic [tisfb_pkg::CHAN_W-1:0]  value,
    input  logic [tisfb_pkg::WIN_W-1:0]   weight,
    input  logic [tisfb_pkg::WIN_W-1:0]   divisor,
    output logic [tisfb_pkg::CHAN_W-1:0]  result
);

    logic [tisfb_pkg::PROD_W-1:0] rem_reg [tisfb_pkg::DIV_STAGES+1];
    logic [tisfb_pkg::CHAN_W-1:0] quo_reg [tisfb_pkg::DIV_STAGES+1];
    logic [tisfb_pkg::WIN_W-1:0]  dvs_reg [tisfb_pkg::DIV_STAGES+1];
    logic [tisfb_pkg::PROD_W-1:0] rem_next [tisfb_pkg::DIV_STAGES];
    logic [tisfb_pkg::CHAN_W-1:0] quo_next [tisfb_pkg::DIV_STAGES];
    logic [tisfb_pkg::CHAN_W-1:0] result_reg;
    logic [tisfb_pkg::CHAN_W-1:0] result_next;
    logic [tisfb_pkg::WIN_W:0]    twice_rem;
    logic                         round_up;

    // Restoring division, BITS_PER_STAGE quotient bits per stage, most significant first.
    always_comb
    begin
        logic [tisfb_pkg::PROD_W-1:0] rem_tmp;
        logic [tisfb_pkg::CHAN_W-1:0] quo_tmp;
        logic [tisfb_pkg::PROD_W-1:0] shifted;
        for (int s = 0; s < tisfb_pkg::DIV_STAGES; s++)
        begin
            rem_tmp = rem_reg[s];
            quo_tmp = quo_reg[s];
            for (int b = 0; b < tisfb_pkg::BITS_PER_STAGE; b++)
            begin
                shifted = tisfb_pkg::PROD_W'(dvs_reg[s])
                          << (tisfb_pkg::CHAN_W - 1 - s * tisfb_pkg::BITS_PER_STAGE - b);
                if (rem_tmp >= shifted)
                begin
                    rem_tmp = rem_tmp - shifted;
                    quo_tmp = quo_tmp | (tisfb_pkg::CHAN_W'(1)
                              << (tisfb_pkg::CHAN_W - 1 - s * tisfb_pkg::BITS_PER_STAGE - b));
                end
            end
            rem_next[s] = rem_tmp;
            quo_next[s] = quo_tmp;
        end
    end

    // Round to nearest; on an exact half, round toward the even quotient.
    always_comb
    begin
        twice_rem   = {rem_reg[tisfb_pkg::DIV_STAGES][tisfb_pkg::WIN_W-1:0], 1'b0};
        round_up    = (twice_rem > {1'b0, dvs_reg[tisfb_pkg::DIV_STAGES]})
                   || ((twice_rem == {1'b0, dvs_reg[tisfb_pkg::DIV_STAGES]})
                       && quo_reg[tisfb_pkg::DIV_STAGES][0]);
        result_next = quo_reg[tisfb_pkg::DIV_STAGES] + tisfb_pkg::CHAN_W'(round_up);
    end

    // Multiply stage, divide stages and rounding register.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {{(tisfb_pkg::PROD_W - tisfb_pkg::CHAN_W){1'b0}}, value}
                    * {{(tisfb_pkg::PROD_W - tisfb_pkg::WIN_W){1'b0}}, weight};
        quo_reg[0] <= '0;
        dvs_reg[0] <= divisor;
        for (int s = 0; s < tisfb_pkg::DIV_STAGES; s++)
        begin
            rem_reg[s+1] <= rem_next[s];
            quo_reg[s+1] <= quo_next[s];
            dvs_reg[s+1] <= dvs_reg[s];
        end
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== rtl/three_image_seam_feather_blend.sv =====
// Throughput: one request per clock; busy never rises, the pipeline has no stalls.
// Latency is set by two passes through the scaling unit (multiply, four
// two-bit divide stages, rounding) plus the geometry register and the output register.
// Reset (rst_n low) clears all valid bits and restores image_width 1920, half_window 100.
module three_image_seam_feather_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [tisfb_pkg::CFG_W-1:0]   cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [tisfb_pkg::COL_W-1:0]   column,
    input  logic [tisfb_pkg::CHAN_W-1:0]  left_ch0,
    input  logic [tisfb_pkg::CHAN_W-1:0]  left_ch1,
    input  logic [tisfb_pkg::CHAN_W-1:0]  left_ch2,
    input  logic [tisfb_pkg::CHAN_W-1:0]  mid_ch0,
    input  logic [tisfb_pkg::CHAN_W-1:0]  mid_ch1,
    input  logic [tisfb_pkg::CHAN_W-1:0]  mid_ch2,
    input  logic [tisfb_pkg::CHAN_W-1:0]  right_ch0,
    input  logic [tisfb_pkg::CHAN_W-1:0]  right_ch1,
    input  logic [tisfb_pkg::CHAN_W-1:0]  right_ch2,
    output logic                          out_valid,
    output logic [tisfb_pkg::CHAN_W-1:0]  out_ch0,
    output logic [tisfb_pkg::CHAN_W-1:0]  out_ch1,
    output logic [tisfb_pkg::CHAN_W-1:0]  out_ch2
);

    logic [tisfb_pkg::WIDTH_W-1:0] image_width_reg;
    logic [tisfb_pkg::HALF_W-1:0]  half_window_reg;

    tisfb_pkg::geo_t   geo;
    logic              accept;

    logic              valid_s1_reg;
    tisfb_pkg::geo_t   geo_s1_reg;
    tisfb_pkg::trio_t  left_s1_reg;
    tisfb_pkg::trio_t  mid_s1_reg;
    tisfb_pkg::trio_t  right_s1_reg;

    tisfb_pkg::side1_t side1_now;
    tisfb_pkg::side1_t side1_reg  [tisfb_pkg::SCALE_LAT];
    logic              valid1_reg [tisfb_pkg::SCALE_LAT];
    tisfb_pkg::side1_t side1_end;

    tisfb_pkg::side2_t side2_now;
    tisfb_pkg::side2_t side2_reg  [tisfb_pkg::SCALE_LAT];
    logic              valid2_reg [tisfb_pkg::SCALE_LAT];
    tisfb_pkg::side2_t side2_end;

    tisfb_pkg::trio_t  left_scaled;
    tisfb_pkg::trio_t  mid_scaled;
    tisfb_pkg::trio_t  right_scaled;
    tisfb_pkg::trio_t  mid_first;
    tisfb_pkg::trio_t  mid_second_scaled;
    tisfb_pkg::trio_t  blend_next;
    tisfb_pkg::trio_t  blend_reg;
    logic              out_valid_reg;

    // The pipeline never stalls, so every request is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= tisfb_pkg::WIDTH_W'(1920);
            half_window_reg <= tisfb_pkg::HALF_W'(100);
        end
        else if (cfg_write)
        begin
            unique case (tisfb_pkg::cfg_reg_t'(cfg_index))
                tisfb_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                tisfb_pkg::REG_HALF_WINDOW: half_window_reg <= cfg_data[tisfb_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: seam geometry of the incoming column.
    tisfb_decode u_decode (
        .column      (column),
        .image_width (image_width_reg),
        .half_window (half_window_reg),
        .geo         (geo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        geo_s1_reg   <= geo;
        left_s1_reg  <= {left_ch2, left_ch1, left_ch0};
        mid_s1_reg   <= {mid_ch2, mid_ch1, mid_ch0};
        right_s1_reg <= {right_ch2, right_ch1, right_ch0};
    end

    // First pass: left and right ramps, first ramp of the center image.
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_pass1
        tisfb_scale u_left (
            .clk     (clk),
            .value   (left_s1_reg[ch]),
            .weight  (geo_s1_reg.rest_first),
            .divisor (geo_s1_reg.window),
            .result  (left_scaled[ch])
        );
        tisfb_scale u_mid (
            .clk     (clk),
            .value   (mid_s1_reg[ch]),
            .weight  (geo_s1_reg.k_first),
            .divisor (geo_s1_reg.window),
            .result  (mid_scaled[ch])
        );
        tisfb_scale u_right (
            .clk     (clk),
            .value   (right_s1_reg[ch]),
            .weight  (geo_s1_reg.k_second),
            .divisor (geo_s1_reg.window),
            .result  (right_scaled[ch])
        );
    end

    // Side data that travels with the first pass.
    always_comb
    begin
        side1_now.below_first  = geo_s1_reg.below_first;
        side1_now.in_first     = geo_s1_reg.in_first;
        side1_now.below_second = geo_s1_reg.below_second;
        side1_now.in_second    = geo_s1_reg.in_second;
        side1_now.rest_second  = geo_s1_reg.rest_second;
        side1_now.window       = geo_s1_reg.window;
        side1_now.left_pix     = left_s1_reg;
        side1_now.mid_pix      = mid_s1_reg;
        side1_now.right_pix    = right_s1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tisfb_pkg::SCALE_LAT; i++)
            begin
                valid1_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid1_reg[0] <= valid_s1_reg;
            for (int i = 1; i < tisfb_pkg::SCALE_LAT; i++)
            begin
                valid1_reg[i] <= valid1_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg[0] <= side1_now;
        for (int i = 1; i < tisfb_pkg::SCALE_LAT; i++)
        begin
            side1_reg[i] <= side1_reg[i-1];
        end
    end

    assign side1_end = side1_reg[tisfb_pkg::SCALE_LAT-1];

    // Pick each term by region after the first pass.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (side1_end.below_first)
            begin
                side2_now.left_term[ch] = side1_end.left_pix[ch];
                mid_first[ch]           = '0;
            end
            else if (side1_end.in_first)
            begin
                side2_now.left_term[ch] = left_scaled[ch];
                mid_first[ch]           = mid_scaled[ch];
            end
            else
            begin
                side2_now.left_term[ch] = '0;
                mid_first[ch]           = side1_end.mid_pix[ch];
            end

            if (side1_end.below_second)
            begin
                side2_now.right_term[ch] = '0;
            end
            else if (side1_end.in_second)
            begin
                side2_now.right_term[ch] = right_scaled[ch];
            end
            else
            begin
                side2_now.right_term[ch] = side1_end.right_pix[ch];
            end
        end
        side2_now.below_second = side1_end.below_second;
        side2_now.in_second    = side1_end.in_second;
    end

    // Second pass: second ramp applied to the center term.
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_pass2
        tisfb_scale u_mid2 (
            .clk     (clk),
            .value   (mid_first[ch]),
            .weight  (side1_end.rest_second),
            .divisor (side1_end.window),
            .result  (mid_second_scaled[ch])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tisfb_pkg::SCALE_LAT; i++)
            begin
                valid2_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid2_reg[0] <= valid1_reg[tisfb_pkg::SCALE_LAT-1];
            for (int i = 1; i < tisfb_pkg::SCALE_LAT; i++)
            begin
                valid2_reg[i] <= valid2_reg[i-1];
            end
        end
    end

    // The first-pass center term also rides along for columns before the second ramp.
    always_ff @(posedge clk)
    begin
        side2_reg[0] <= side2_now;
        for (int i = 1; i < tisfb_pkg::SCALE_LAT; i++)
        begin
            side2_reg[i] <= side2_reg[i-1];
        end
    end

    assign side2_end = side2_reg[tisfb_pkg::SCALE_LAT-1];

    tisfb_pkg::trio_t mid_first_reg [tisfb_pkg::SCALE_LAT];

    always_ff @(posedge clk)
    begin
        mid_first_reg[0] <= mid_first;
        for (int i = 1; i < tisfb_pkg::SCALE_LAT; i++)
        begin
            mid_first_reg[i] <= mid_first_reg[i-1];
        end
    end

    // Final center term, sum of the three terms and saturation.
    always_comb
    begin
        logic [tisfb_pkg::CHAN_W-1:0] mid_term;
        logic [tisfb_pkg::CHAN_W+1:0] sum;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (side2_end.below_second)
            begin
                mid_term = mid_first_reg[tisfb_pkg::SCALE_LAT-1][ch];
            end
            else if (side2_end.in_second)
            begin
                mid_term = mid_second_scaled[ch];
            end
            else
            begin
                mid_term = '0;
            end
            sum = (tisfb_pkg::CHAN_W+2)'(side2_end.left_term[ch])
                + (tisfb_pkg::CHAN_W+2)'(mid_term)
                + (tisfb_pkg::CHAN_W+2)'(side2_end.right_term[ch]);
            if (sum > (tisfb_pkg::CHAN_W+2)'(255))
            begin
                blend_next[ch] = tisfb_pkg::CHAN_W'(255);
            end
            else
            begin
                blend_next[ch] = sum[tisfb_pkg::CHAN_W-1:0];
            end
        end
    end

    // Output register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid2_reg[tisfb_pkg::SCALE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        blend_reg <= blend_next;
    end

    assign out_valid = out_valid_reg;
    assign out_ch0   = blend_reg[0];
    assign out_ch1   = blend_reg[1];
    assign out_ch2   = blend_reg[2];

endmodule
